// File: hw/rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types and constants for the FTP command classifier: verdict codes,
// ASCII codes and the table of recognized command verbs.
// ----------------------------------------------------------------------------
package fcc_pkg;

   // Verdict codes
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_USER  = 2'd1,
      KIND_PASS  = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   // ASCII codes
   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_TAB   = 8'h09;

   // Packet head: first five bytes are kept for matching
   localparam int HEAD_LEN = 5;
   // First byte position at which the line body (username) starts
   localparam int BODY_START = 5;

   // Command prefixes; first character in the most significant byte
   localparam logic [39:0] PAT_USER = "user ";
   localparam logic [39:0] PAT_PASS = "pass ";

   // Verb table; three-letter verbs are padded with a space and compared on
   // their top three bytes only
   localparam int VERB_COUNT = 17;
   typedef logic [31:0] verb_type;
   localparam verb_type VERB_TABLE [VERB_COUNT] = '{
      "quit", "syst", "feat", "pwd ", "cwd ", "list", "retr", "stor",
      "port", "pasv", "epsv", "type", "mode", "stru", "help", "noop", "auth"
   };
   localparam logic [2:0] VERB_LEN [VERB_COUNT] = '{
      3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
   };

   // ASCII lower-case fold
   function automatic logic [7:0] to_lower(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] b);
      return (b == ASCII_SPACE) || (b == ASCII_TAB);
   endfunction

endpackage

// File: hw/rtl/ftp_command_classifier_core.sv
// ----------------------------------------------------------------------------
// ftp_command_classifier_core
// Classifies the first command line of one FTP control-channel payload and
// emits the trimmed username of a USER command, one byte per result.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one payload byte per request, req_tlast on the final byte. The
//           flow tags in req_tdata are taken from the first byte only.
//   rsp_* : verdicts. A USER line with a non-empty name gives one result per
//           name byte (rsp_tuser name_valid set, rsp_tlast on the last one);
//           any other packet gives a single result with name_valid clear.
// Throughput: one byte per cycle while the packet streams in. After the
//   final byte, req_tready stays low until the verdict or the last name
//   byte is loaded; the name run is paced by the one read port of the
//   name memory, which delivers one stored byte per cycle unless the
//   output register is held by a low rsp_tready.
// Sequence: after the final byte, ST_CLASSIFY loads the verdict into the
//   output register, or fetches the first name byte for ST_NAME.
// Stall: results wait in an output register; with rsp_tready low the name
//   run pauses and the next packet is taken only once the last result of
//   this one sits in that register.
// Reset: synchronous; clears the packet state, the output valid flag and the
//   flow latch control. The name memory needs no clearing pass.
// ----------------------------------------------------------------------------
module ftp_command_classifier_core
   import fcc_pkg::*;
#(
   parameter int SCAN_WINDOW = 512,
   parameter int NAME_MAX    = 63
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // data_byte[7:0], src_addr[39:8],
                                    // dst_addr[71:40], dest_port[87:72]
   input  logic        req_tlast,   // last_byte
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // name_byte[7:0], flow_src[39:8],
                                    // flow_dst[71:40], flow_port[87:72]
   output logic [2:0]  rsp_tuser,   // kind[1:0], name_valid[2]
   output logic        rsp_tlast    // run_end
);

   localparam int POS_W = 16;
   localparam int LW    = $clog2(SCAN_WINDOW);
   localparam int FW    = $clog2(NAME_MAX + 1);
   localparam int AW    = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

   typedef enum logic [1:0] {
      ST_SCAN,
      ST_CLASSIFY,
      ST_NAME
   } state_type;

   // control state
   state_type        state_ff,      state_in;
   logic [POS_W-1:0] byte_pos_ff,   byte_pos_in;
   logic             line_found_ff, line_found_in;
   logic [LW-1:0]    line_len_ff,   line_len_in;
   logic [FW-1:0]    fill_ff,       fill_in;
   logic [FW-1:0]    keep_ff,       keep_in;
   logic             skip_ff,       skip_in;
   logic             prev_cr_ff,    prev_cr_in;
   logic [FW-1:0]    name_idx_ff,   name_idx_in;
   logic             rsp_valid_ff,  rsp_valid_in;

   // payload state
   logic [7:0]       head_ff [HEAD_LEN];
   logic [7:0]       head_in [HEAD_LEN];
   logic [31:0]      src_ff,  src_in;
   logic [31:0]      dst_ff,  dst_in;
   logic [15:0]      port_ff, port_in;
   kind_type         rsp_kind_ff,  rsp_kind_in;
   logic [7:0]       rsp_byte_ff,  rsp_byte_in;
   logic             rsp_nv_ff,    rsp_nv_in;
   logic             rsp_end_ff,   rsp_end_in;
   logic [31:0]      rsp_src_ff,   rsp_src_in;
   logic [31:0]      rsp_dst_ff,   rsp_dst_in;
   logic [15:0]      rsp_port_ff,  rsp_port_in;

   // name memory
   logic [7:0]       name_mem [NAME_MAX];
   logic [7:0]       rd_data_ff;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [7:0]       wr_data;
   logic             rd_en;
   logic [FW-1:0]    rd_addr;

   // working signals
   logic             req_fire;
   logic             out_free;
   logic [7:0]       in_byte;
   logic [FW-1:0]    fill_w;
   logic [FW-1:0]    keep_w;
   logic             skip_w;
   logic [39:0]      head_lc;
   logic             verb_hit;
   kind_type         class_kind;
   logic [FW-1:0]    idx_next;

   assign req_tready = (state_ff == ST_SCAN);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_byte    = req_tdata[7:0];
   assign idx_next   = name_idx_ff + FW'(1);

   // Lower-cased head, first byte in the top bits
   assign head_lc = {to_lower(head_ff[0]), to_lower(head_ff[1]), to_lower(head_ff[2]),
                     to_lower(head_ff[3]), to_lower(head_ff[4])};

   // Verb match over the table
   always_comb begin
      verb_hit = 1'b0;
      for (int i = 0; i < VERB_COUNT; i++) begin
         if (VERB_LEN[i] == 3'd3) begin
            if (line_len_ff >= LW'(3) && head_lc[39:16] == VERB_TABLE[i][31:8]) begin
               verb_hit = 1'b1;
            end
         end else begin
            if (line_len_ff >= LW'(4) && head_lc[39:8] == VERB_TABLE[i]) begin
               verb_hit = 1'b1;
            end
         end
      end
   end

   // Verdict from the stored line head
   always_comb begin
      class_kind = KIND_NONE;
      if (byte_pos_ff >= POS_W'(HEAD_LEN) && line_found_ff) begin
         if (line_len_ff >= LW'(HEAD_LEN) && head_lc == PAT_USER) begin
            class_kind = KIND_USER;
         end else if (line_len_ff >= LW'(HEAD_LEN) && head_lc == PAT_PASS) begin
            class_kind = KIND_PASS;
         end else if (verb_hit) begin
            class_kind = KIND_OTHER;
         end
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      byte_pos_in   = byte_pos_ff;
      line_found_in = line_found_ff;
      line_len_in   = line_len_ff;
      fill_in       = fill_ff;
      keep_in       = keep_ff;
      skip_in       = skip_ff;
      prev_cr_in    = prev_cr_ff;
      name_idx_in   = name_idx_ff;
      head_in       = head_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      port_in       = port_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_nv_in     = rsp_nv_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      rsp_port_in   = rsp_port_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      fill_w        = fill_ff;
      keep_w        = keep_ff;
      skip_w        = skip_ff;

      case (state_ff)
         ST_SCAN: begin
            if (req_fire) begin
               // flow tags come with the first byte
               if (byte_pos_ff == '0) begin
                  src_in  = req_tdata[39:8];
                  dst_in  = req_tdata[71:40];
                  port_in = req_tdata[87:72];
               end
               if (byte_pos_ff != '1) begin
                  byte_pos_in = byte_pos_ff + POS_W'(1);
               end
               if (!line_found_ff && byte_pos_ff < POS_W'(SCAN_WINDOW)) begin
                  if (in_byte == ASCII_LF) begin
                     line_found_in = 1'b1;
                     line_len_in   = (prev_cr_ff && byte_pos_ff != '0) ?
                                     LW'(byte_pos_ff - POS_W'(1)) : LW'(byte_pos_ff);
                     prev_cr_in    = 1'b0;
                  end else begin
                     // held CR joins the name; its byte was written already
                     if (prev_cr_ff && byte_pos_ff >= POS_W'(BODY_START + 1)) begin
                        skip_w = 1'b0;
                        if (fill_w < FW'(NAME_MAX)) begin
                           fill_w = fill_w + FW'(1);
                        end
                        keep_w = fill_w;
                     end
                     if (byte_pos_ff < POS_W'(HEAD_LEN)) begin
                        head_in[byte_pos_ff[2:0]] = in_byte;
                     end
                     prev_cr_in = (in_byte == ASCII_CR);
                     if (byte_pos_ff >= POS_W'(BODY_START)) begin
                        if (in_byte == ASCII_CR) begin
                           // park the CR in the next free slot, uncommitted
                           if (fill_w < FW'(NAME_MAX)) begin
                              wr_en   = 1'b1;
                              wr_addr = fill_w[AW-1:0];
                              wr_data = ASCII_CR;
                           end
                        end else if (!(skip_w && is_blank(in_byte))) begin
                           skip_w = 1'b0;
                           if (fill_w < FW'(NAME_MAX)) begin
                              wr_en   = 1'b1;
                              wr_addr = fill_w[AW-1:0];
                              wr_data = in_byte;
                              fill_w  = fill_w + FW'(1);
                           end
                           if (!is_blank(in_byte)) begin
                              keep_w = fill_w;
                           end
                        end
                     end
                     fill_in = fill_w;
                     keep_in = keep_w;
                     skip_in = skip_w;
                  end
               end
               if (req_tlast) begin
                  state_in = ST_CLASSIFY;
               end
            end
         end

         ST_CLASSIFY: begin
            if (class_kind == KIND_USER && keep_ff != '0) begin
               // start the name run: fetch the first byte
               rd_en       = 1'b1;
               rd_addr     = '0;
               name_idx_in = '0;
               state_in    = ST_NAME;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = class_kind;
               rsp_byte_in  = '0;
               rsp_nv_in    = 1'b0;
               rsp_end_in   = 1'b1;
               rsp_src_in   = src_ff;
               rsp_dst_in   = dst_ff;
               rsp_port_in  = port_ff;
               state_in     = ST_SCAN;
            end
         end

         ST_NAME: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_USER;
               rsp_byte_in  = rd_data_ff;
               rsp_nv_in    = 1'b1;
               rsp_end_in   = (idx_next == keep_ff);
               rsp_src_in   = src_ff;
               rsp_dst_in   = dst_ff;
               rsp_port_in  = port_ff;
               name_idx_in  = idx_next;
               rd_addr      = idx_next;
               if (idx_next == keep_ff) begin
                  state_in = ST_SCAN;
               end
            end else begin
               rd_addr = name_idx_ff;
            end
            rd_en = (rd_addr < FW'(NAME_MAX));
         end

         default: begin
            state_in = ST_SCAN;
         end
      endcase

      // packet state returns to its reset value once the last result is loaded
      if (state_ff != ST_SCAN && state_in == ST_SCAN) begin
         byte_pos_in   = '0;
         line_found_in = 1'b0;
         line_len_in   = '0;
         fill_in       = '0;
         keep_in       = '0;
         skip_in       = 1'b1;
         prev_cr_in    = 1'b0;
      end
   end

   // Name memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= name_mem[rd_addr[AW-1:0]];
      end
   end

   // State and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SCAN;
         byte_pos_ff   <= '0;
         line_found_ff <= 1'b0;
         line_len_ff   <= '0;
         fill_ff       <= '0;
         keep_ff       <= '0;
         skip_ff       <= 1'b1;
         prev_cr_ff    <= 1'b0;
         name_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         byte_pos_ff   <= byte_pos_in;
         line_found_ff <= line_found_in;
         line_len_ff   <= line_len_in;
         fill_ff       <= fill_in;
         keep_ff       <= keep_in;
         skip_ff       <= skip_in;
         prev_cr_ff    <= prev_cr_in;
         name_idx_ff   <= name_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         port_ff       <= port_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_nv_ff     <= rsp_nv_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_src_ff    <= rsp_src_in;
         rsp_dst_ff    <= rsp_dst_in;
         rsp_port_ff   <= rsp_port_in;
      end
   end

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_port_ff, rsp_dst_ff, rsp_src_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_nv_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_end_ff;

   // Checks
   a_keep_le_fill: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= fill_ff)
      else $error("name keep count beyond fill count");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_NAME |-> name_idx_ff < keep_ff)
      else $error("name index outside kept name");

   a_name_is_user: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nv_ff |-> rsp_kind_ff == KIND_USER)
      else $error("name byte with a verdict other than user");

   a_single_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_nv_ff |-> rsp_end_ff)
      else $error("single verdict without run end");

   a_line_len: assert property (@(posedge clock) disable iff (reset)
      line_found_ff |-> POS_W'(line_len_ff) < byte_pos_ff)
      else $error("line length beyond bytes seen");

endmodule

// File: dv/ftp_command_classifier_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftp_command_classifier_core_test
// Self-checking bench for the FTP command classifier. Payload bytes are
// streamed one per request, with idle bursts on both sides of the block.
// A behavioral predictor follows every accepted request and builds the
// expected verdict or username run. Each result is compared field by field
// with the oldest expected one. The stimulus has a directed set (corner
// lines, short packets, a name that overruns the store), then random
// packets, mostly well-formed commands with random content.
// ----------------------------------------------------------------------------
module ftp_command_classifier_core_test
   import fcc_pkg::*;
();

   localparam int WINDOW        = 512;
   localparam int NAME_LIMIT    = 63;
   localparam int POS_CEILING   = 65535;
   localparam int LONG_STALL    = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4000000;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Command heads, first character in the top byte
   localparam logic [39:0] USER_HEAD = "user ";
   localparam logic [39:0] PASS_HEAD = "pass ";
   localparam int          VERB_NUM  = 17;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] port;
   } byte_req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  name_byte;
      logic        name_valid;
      logic [31:0] flow_src;
      logic [31:0] flow_dst;
      logic [15:0] flow_port;
      logic        run_end;
   } verdict_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata  = '0;   // data_byte, src_addr, dst_addr, dest_port
   logic        req_tlast  = 1'b0; // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;         // name_byte, flow_src, flow_dst, flow_port
   logic [2:0]  rsp_tuser;         // kind[1:0], name_valid
   logic        rsp_tlast;         // run_end

   byte_req_type byte_reqs[$];     // requests waiting for the driver
   logic [7:0]   pkt_bytes[$];     // packet under construction
   verdict_type  verdicts[$];      // expected results, oldest first

   // Driver / receiver bookkeeping
   bit           req_busy;
   bit           idle_enable = 1'b1;
   int           req_gap, req_calm;
   int           stall_left, rsp_calm;
   bit           long_stall_done;
   int           packets_taken;
   int           fail_count;
   int           verb_ix;
   byte_req_type cur_req;

   // Predictor state
   int unsigned scan_pos;
   bit          line_seen;
   int unsigned line_len;
   logic [7:0]  head_q[5];
   logic [7:0]  name_mem[NAME_LIMIT];
   int unsigned name_fill, name_keep;
   bit          skip_lead = 1'b1;
   bit          cr_held;
   logic [31:0] lat_src, lat_dst;
   logic [15:0] lat_port;

   ftp_command_classifier_core #(
      .SCAN_WINDOW(WINDOW),
      .NAME_MAX   (NAME_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'h20 : b;
   endfunction

   function automatic bit is_space_or_tab(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB);
   endfunction

   function automatic logic [31:0] verb_at(input int ix);
      case (ix)
         0:       return "quit";
         1:       return "syst";
         2:       return "feat";
         3:       return "pwd ";
         4:       return "cwd ";
         5:       return "list";
         6:       return "retr";
         7:       return "stor";
         8:       return "port";
         9:       return "pasv";
         10:      return "epsv";
         11:      return "type";
         12:      return "mode";
         13:      return "stru";
         14:      return "help";
         15:      return "noop";
         default: return "auth";
      endcase
   endfunction

   function automatic bit head_is(input logic [39:0] pat, input int n);
      int i;
      if (line_len < n) return 1'b0;
      for (i = 0; i < n; i++) begin
         if (fold_case(head_q[i[2:0]]) != pat[39-8*i -: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Username body: leading blanks dropped, trailing blanks trimmed by keep
   task automatic add_name_byte(input logic [7:0] b);
      if (skip_lead && is_space_or_tab(b)) return;
      skip_lead = 1'b0;
      if (name_fill < NAME_LIMIT) begin
         name_mem[name_fill[5:0]] = b;
         name_fill++;
      end
      if (!is_space_or_tab(b)) name_keep = name_fill;
   endtask

   task automatic classify_step(input logic [7:0] b, input logic last_b,
                                input logic [31:0] s, input logic [31:0] d,
                                input logic [15:0] p);
      int          i;
      int          vlen;
      kind_type    k;
      verdict_type v;
      if (scan_pos == 0) begin
         lat_src  = s;
         lat_dst  = d;
         lat_port = p;
      end
      // Line scan inside the window; a CR waits one byte to see if LF follows
      if (!line_seen && scan_pos < WINDOW) begin
         if (b == CH_LF) begin
            line_seen = 1'b1;
            line_len  = (cr_held && scan_pos > 0) ? scan_pos - 1 : scan_pos;
            cr_held   = 1'b0;
         end else begin
            if (cr_held && scan_pos >= 6) add_name_byte(CH_CR);
            if (scan_pos < 5) head_q[scan_pos[2:0]] = b;
            cr_held = (b == CH_CR);
            if (scan_pos >= 5 && b != CH_CR) add_name_byte(b);
         end
      end
      if (scan_pos < POS_CEILING) scan_pos++;
      if (!last_b) return;

      // Verdict on the final byte
      k = KIND_NONE;
      if (scan_pos >= 5 && line_seen) begin
         if (head_is(USER_HEAD, 5)) begin
            k = KIND_USER;
         end else if (head_is(PASS_HEAD, 5)) begin
            k = KIND_PASS;
         end else begin
            for (i = 0; i < VERB_NUM; i++) begin
               vlen = (verb_at(i) & 32'hFF) == CH_SPACE ? 3 : 4;
               if (head_is({verb_at(i), 8'h00}, vlen)) k = KIND_OTHER;
            end
         end
      end
      v.kind      = k;
      v.flow_src  = lat_src;
      v.flow_dst  = lat_dst;
      v.flow_port = lat_port;
      if (k == KIND_USER && name_keep > 0) begin
         for (i = 0; i < name_keep; i++) begin
            v.name_byte  = name_mem[i[5:0]];
            v.name_valid = 1'b1;
            v.run_end    = (i + 1 == name_keep);
            verdicts.push_back(v);
         end
      end else begin
         v.name_byte  = 8'h00;
         v.name_valid = 1'b0;
         v.run_end    = 1'b1;
         verdicts.push_back(v);
      end
      scan_pos  = 0;
      line_seen = 1'b0;
      line_len  = 0;
      name_fill = 0;
      name_keep = 0;
      skip_lead = 1'b1;
      cr_held   = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Packet construction
   // ------------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] b);
      pkt_bytes.push_back(b);
   endtask

   // Letters get a random case when mix is set
   task automatic add_char(input logic [7:0] b, input bit mix);
      if (mix && fold_case(b) >= "a" && fold_case(b) <= "z" && $urandom_range(0, 1))
         b = b ^ 8'h20;
      pkt_bytes.push_back(b);
   endtask

   task automatic add_text(input string s, input bit mix);
      int i;
      for (i = 0; i < s.len(); i++) add_char(s[i], mix);
   endtask

   task automatic add_blanks(input int n);
      repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endtask

   // Username-like content: mostly printable, some blanks, CRs and raw bytes
   task automatic add_name(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 19);
         if (r < 2)       add_blanks(1);
         else if (r == 2) add_byte(CH_CR);
         else if (r == 3) add_byte(8'($urandom));
         else             add_byte(8'($urandom_range(8'h21, 8'h7E)));
      end
   endtask

   task automatic add_ending();
      case ($urandom_range(0, 5))
         0, 1: add_text("\015\012", 0);
         2:    add_byte(CH_LF);
         3:    add_text("\015\015\012", 0);
         4:    ;  // line never ends
         default: begin
            add_byte(CH_LF);
            repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
         end
      endcase
   endtask

   // Verbs are taken from the table in turn
   task automatic add_verb();
      logic [31:0] v;
      int          i;
      v = verb_at(verb_ix % VERB_NUM);
      verb_ix++;
      for (i = 0; i < 4; i++) begin
         if (v[31-8*i -: 8] != CH_SPACE) add_char(v[31-8*i -: 8], 1'b1);
      end
   endtask

   // Flow tags ride on the first byte; later bytes carry junk tags
   task automatic send_packet(input logic [31:0] s, input logic [31:0] d,
                              input logic [15:0] p);
      byte_req_type r;
      int           i;
      if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom));
      for (i = 0; i < pkt_bytes.size(); i++) begin
         r.data = pkt_bytes[i];
         r.last = (i == pkt_bytes.size() - 1);
         if (i == 0) begin
            r.src  = s;
            r.dst  = d;
            r.port = p;
         end else begin
            r.src  = $urandom;
            r.dst  = $urandom;
            r.port = 16'($urandom);
         end
         byte_reqs.push_back(r);
      end
      pkt_bytes.delete();
   endtask

   task automatic send_random_tags();
      send_packet($urandom, $urandom, 16'($urandom_range(0, 65535)));
   endtask

   task automatic random_packet();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         add_text("user ", 1);
         add_blanks($urandom_range(0, 3));
         add_name($urandom_range(0, 12));
         add_blanks($urandom_range(0, 3));
         add_ending();
      end else if (sel < 45) begin
         add_text("pass ", 1);
         add_name($urandom_range(0, 16));
         add_ending();
      end else if (sel < 65) begin
         add_verb();
         if ($urandom_range(0, 1)) add_byte(CH_SPACE);
         add_name($urandom_range(0, 8));
         add_ending();
      end else if (sel < 78) begin
         // heads close to a known one, some of which still match
         case ($urandom_range(0, 5))
            0: add_text("user", 1);
            1: add_text("usr ", 1);
            2: add_text(" user ", 1);
            3: begin add_text("pas", 1); add_byte(8'($urandom)); end
            4: add_text("pw", 1);
            default: begin
               add_text("lis", 1);
               add_byte(8'($urandom_range(8'h61, 8'h7A)));
            end
         endcase
         add_name($urandom_range(0, 8));
         add_ending();
      end else if (sel < 90) begin
         repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
         if ($urandom_range(0, 1)) add_byte(CH_LF);
      end else begin
         // short packets from a command-like alphabet
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 5))
               0: add_byte(CH_LF);
               1: add_byte(CH_CR);
               2: add_byte(CH_SPACE);
               3: add_char("u", 1);
               4: add_char("p", 1);
               default: add_byte(8'($urandom));
            endcase
         end
      end
      send_random_tags();
   endtask

   // ------------------------------------------------------------------------
   // Request driver: one item held until accepted, idle bursts in between
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_calm > 0) req_calm--;
         else if ($urandom_range(0, 199) == 0) req_calm = $urandom_range(40, 160);
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (idle_enable && req_calm == 0 && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 17) - 1;
               req_tvalid <= 1'b0;
            end else if (byte_reqs.size() != 0) begin
               cur_req = byte_reqs.pop_front();
               req_tdata  <= {cur_req.port, cur_req.dst, cur_req.src, cur_req.data};
               req_tlast  <= cur_req.last;
               req_tvalid <= 1'b1;
               req_busy   = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result receiver: random stalls plus one long hold-off
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_calm > 0) rsp_calm--;
         else if ($urandom_range(0, 199) == 0) rsp_calm = $urandom_range(40, 160);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!long_stall_done && packets_taken >= 6) begin
            long_stall_done = 1'b1;
            stall_left = LONG_STALL - 1;
            rsp_tready <= 1'b0;
         end else if (idle_enable && rsp_calm == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on each accepted request, check each accepted result
   // ------------------------------------------------------------------------
   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endtask

   task automatic check_result();
      verdict_type exp_v;
      if (verdicts.size() == 0) begin
         fail_count++;
         $display("%0t: result with nothing expected, expected none, actual %h/%h/%b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
      end else begin
         exp_v = verdicts.pop_front();
         check_field("kind",       32'(exp_v.kind),       32'(rsp_tuser[1:0]));
         check_field("name_valid", 32'(exp_v.name_valid), 32'(rsp_tuser[2]));
         check_field("name_byte",  32'(exp_v.name_byte),  32'(rsp_tdata[7:0]));
         check_field("flow_src",   exp_v.flow_src,        rsp_tdata[39:8]);
         check_field("flow_dst",   exp_v.flow_dst,        rsp_tdata[71:40]);
         check_field("flow_port",  32'(exp_v.flow_port),  32'(rsp_tdata[87:72]));
         check_field("run_end",    32'(exp_v.run_end),    32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            classify_step(req_tdata[7:0], req_tlast, req_tdata[39:8],
                          req_tdata[71:40], req_tdata[87:72]);
            req_busy = 1'b0;
            if (req_tlast) packets_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // Hard stop
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      // Directed packets
      add_text("USER alice\015\012", 0);
      send_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      add_text("user  \011 Bob Smith \011\015\012", 0);
      send_packet(32'h0, 32'h0, 16'h0);
      add_text("PASS secret\015\012", 0);
      send_random_tags();
      add_text("pWd\015\012", 0);
      send_random_tags();
      add_text("QuIt\015\012", 0);
      send_random_tags();
      add_text("AUTH TLS\012", 0);
      send_random_tags();
      // short packets: three bytes, a lone LF, a four-byte verb line
      add_text("USE", 0);
      send_random_tags();
      add_byte(CH_LF);
      send_random_tags();
      add_text("pwd\012", 0);
      send_random_tags();
      // no line end, empty name, headless line, early LF
      add_text("USER nolf", 0);
      send_random_tags();
      add_text("USER \011 \015\012", 0);
      send_random_tags();
      add_text("USER\015\012", 0);
      send_random_tags();
      add_text("\015\012USER x\012", 0);
      send_random_tags();
      add_text("XUSER bob\012", 0);
      send_random_tags();
      // held CR inside the name, and a CR left dangling at the end
      add_text("USER a\015b\015\015\012", 0);
      send_random_tags();
      add_text("USER ab\015", 0);
      send_random_tags();
      // extreme byte values in the name
      add_text("USER ", 0);
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(8'h80);
      add_byte(CH_LF);
      send_random_tags();
      // name longer than the store, with a blank landing on the last slot
      add_text("USER ", 0);
      repeat (62) add_byte("m");
      add_text("  z\012", 0);
      send_random_tags();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender pause until every expected result is in
      while (byte_reqs.size() != 0 || req_busy || verdicts.size() != 0)
         @(posedge clock);

      // Random packets
      repeat (4) random_packet();
      while (byte_reqs.size() != 0) @(posedge clock);

      // closing stretch without idling
      idle_enable = 1'b0;
      repeat (3) random_packet();

      while (byte_reqs.size() != 0 || req_busy || verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
